// ===== hdl/assert_macros.svh =====
// assertion macros shared by the framer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a clock, switched off while reset is asserted
`define SFB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication check: when cond holds, expr must hold in the same cycle
`define SFB_ASSERT_IMP(label, clk, rst_n, cond, expr, msg) \
	`SFB_ASSERT(label, clk, rst_n, (cond) |-> (expr), msg)

`endif

// ===== hdl/sfb_pkg.sv =====
// types and constants of the stuffed frame builder
package sfb_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned INDEX_W = 3;

	// configuration register indexes
	localparam logic [INDEX_W-1:0] REG_FLAG    = 3'd0;
	localparam logic [INDEX_W-1:0] REG_ESCAPE  = 3'd1;
	localparam logic [INDEX_W-1:0] REG_ADDRESS = 3'd2;
	localparam logic [INDEX_W-1:0] REG_CTRL_EV = 3'd3;
	localparam logic [INDEX_W-1:0] REG_CTRL_OD = 3'd4;

	// reset values of the registers
	localparam logic [BYTE_W-1:0] FLAG_RST    = 8'd126;
	localparam logic [BYTE_W-1:0] ESCAPE_RST  = 8'd125;
	localparam logic [BYTE_W-1:0] ADDRESS_RST = 8'd3;
	localparam logic [BYTE_W-1:0] CTRL_EV_RST = 8'd0;
	localparam logic [BYTE_W-1:0] CTRL_OD_RST = 8'd64;

	// xor applied to the byte after an escape
	localparam logic [BYTE_W-1:0] STUFF_MASK = 8'h20;

	// configuration seen by front and back
	typedef struct packed {
		logic [BYTE_W-1:0] flag;
		logic [BYTE_W-1:0] escape;
		logic [BYTE_W-1:0] address;
		logic [BYTE_W-1:0] ctrl_even;
		logic [BYTE_W-1:0] ctrl_odd;
	} cfg_t;

	// one classified payload beat, as queued between front and back
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              open;
		logic [BYTE_W-1:0] ctrl;
		logic [BYTE_W-1:0] chk;
	} rec_t;

	// emission steps of the back end
	typedef enum logic [2:0] {
		ST_START,
		ST_OPEN,
		ST_ADDR,
		ST_CTRL,
		ST_HCS,
		ST_DATA,
		ST_CHECK,
		ST_CLOSE
	} step_t;

endpackage

// ===== hdl/sfb_front.sv =====
// front end: accepts payload beats and tracks frame state
module sfb_front
	import sfb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              push,
	input  logic              q_full,
	input  logic [BYTE_W-1:0] payload_byte,
	input  logic              frame_last,
	output logic              q_push,
	output rec_t              q_rec
);

	logic              inside_q;
	logic              seq_q;
	logic [BYTE_W-1:0] pc_q;
	logic [BYTE_W-1:0] chk;

	// classify the incoming beat
	assign q_push = push && !q_full;
	assign chk    = (inside_q ? pc_q : '0) ^ payload_byte;

	always_comb begin
		q_rec.data = payload_byte;
		q_rec.last = frame_last;
		q_rec.open = !inside_q;
		q_rec.ctrl = seq_q ? cfg.ctrl_odd : cfg.ctrl_even;
		q_rec.chk  = chk;
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			seq_q    <= 1'b0;
			pc_q     <= '0;
		end else if (q_push) begin
			if (!inside_q) begin
				seq_q <= !seq_q;
			end
			inside_q <= !frame_last;
			pc_q     <= frame_last ? '0 : chk;
		end
	end

endmodule

// ===== hdl/sfb_queue.sv =====
// short queue of classified beats between front and back
`include "assert_macros.svh"
module sfb_queue
	import sfb_pkg::*;
#(
	parameter int unsigned DEPTH = 4
)
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t wr_rec,
	output logic full,
	input  logic pop,
	output rec_t rd_rec,
	output logic valid
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	rec_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;
	logic          grow;

	assign full    = (cnt_q == CW'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign grow    = do_push && !do_pop;
	assign rd_rec  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wr_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (grow) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	`SFB_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CW'(DEPTH), "queue count beyond depth")
	`SFB_ASSERT(a_cnt_push, clk, arst_n, grow |=> (cnt_q == $past(cnt_q) + CW'(1)), "missed push")

endmodule

// ===== hdl/sfb_back.sv =====
// back end: expands each beat into stuffed line bytes
`include "assert_macros.svh"
module sfb_back
	import sfb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              q_valid,
	input  rec_t              q_rec,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output logic [BYTE_W-1:0] line_byte,
	output logic              frame_done,
	output logic              run_last
);

	step_t             step_q;
	step_t             step_d;
	step_t             cur;
	step_t             nxt;
	logic              esc_pend_q;
	logic              esc_pend_d;
	logic              out_valid_q;
	logic              adv;
	logic              stuffable;
	logic              need_esc;
	logic              fin_byte;
	logic              item_end;
	logic [BYTE_W-1:0] byte_sel;
	logic [BYTE_W-1:0] byte_out;

	assign empty = !out_valid_q;
	assign adv   = q_valid && (!out_valid_q || pop);

	// step sequencing and byte choice
	always_comb begin
		if (step_q == ST_START) begin
			cur = q_rec.open ? ST_OPEN : ST_DATA;
		end else begin
			cur = step_q;
		end
		stuffable = 1'b1;
		case (cur)
			ST_OPEN: begin
				byte_sel  = cfg.flag;
				stuffable = 1'b0;
				nxt       = ST_ADDR;
			end
			ST_ADDR: begin
				byte_sel = cfg.address;
				nxt      = ST_CTRL;
			end
			ST_CTRL: begin
				byte_sel = q_rec.ctrl;
				nxt      = ST_HCS;
			end
			ST_HCS: begin
				byte_sel = cfg.address ^ q_rec.ctrl;
				nxt      = ST_DATA;
			end
			ST_DATA: begin
				byte_sel = q_rec.data;
				nxt      = q_rec.last ? ST_CHECK : ST_START;
			end
			ST_CHECK: begin
				byte_sel = q_rec.chk;
				nxt      = ST_CLOSE;
			end
			ST_CLOSE: begin
				byte_sel  = cfg.flag;
				stuffable = 1'b0;
				nxt       = ST_START;
			end
			default: begin
				byte_sel  = cfg.flag;
				stuffable = 1'b0;
				nxt       = ST_START;
			end
		endcase
		need_esc = stuffable && ((byte_sel == cfg.flag) || (byte_sel == cfg.escape));
		fin_byte = esc_pend_q || !need_esc;
		item_end = fin_byte && (nxt == ST_START);
		if (esc_pend_q) begin
			byte_out = byte_sel ^ STUFF_MASK;
		end else if (need_esc) begin
			byte_out = cfg.escape;
		end else begin
			byte_out = byte_sel;
		end
		step_d     = step_q;
		esc_pend_d = esc_pend_q;
		if (adv) begin
			esc_pend_d = !fin_byte;
			if (fin_byte) begin
				step_d = nxt;
			end else begin
				step_d = cur;
			end
		end
		q_pop = adv && item_end;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= ST_START;
			esc_pend_q <= 1'b0;
		end else begin
			step_q     <= step_d;
			esc_pend_q <= esc_pend_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			line_byte  <= byte_out;
			frame_done <= fin_byte && (cur == ST_CLOSE);
			run_last   <= item_end;
		end
	end

	`SFB_ASSERT_IMP(a_esc_has_item, clk, arst_n, esc_pend_q, q_valid, "escape pending with no beat queued")

endmodule

// ===== hdl/stuffed_frame_builder_top.sv =====
// top level of the stuffed frame builder
//
// Payload beats enter on a queue-style port: a beat is taken at a clock
// edge with push high and full low, frame_last marking the frame's end.
// Line bytes leave on a second queue-style port: the oldest byte shows on
// line_byte, frame_done and run_last while empty is low, and is taken at
// an edge with pop high. The first beat of a frame brings the opening flag
// and header, the last beat the payload check and closing flag; stuffed
// bytes come out as escape then byte xor 0x20.
// Registers are written over cfg_valid/cfg_ready, index and data; ready is
// always high, writes are meant only while the block is idle.
// A beat's first byte passes through the queue, then the back end's output
// register. The sequencer gives one line byte per cycle while a beat waits
// and the receiver keeps up; each beat makes 1 to 12 line bytes.
// The front end keeps taking beats into a DEPTH-entry queue while the back
// end works; when the receiver stalls the output register holds and the
// queue fills, then full rises.
// Reset closes any open frame, clears the sequence bit and payload check,
// empties the queue and restores register defaults.
`include "assert_macros.svh"
module stuffed_frame_builder_top
	import sfb_pkg::*;
#(
	parameter int unsigned DEPTH = 4
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [BYTE_W-1:0]  payload_byte,
	input  logic               frame_last,
	input  logic               pop,
	output logic               empty,
	output logic [BYTE_W-1:0]  line_byte,
	output logic               frame_done,
	output logic               run_last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [INDEX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]  cfg_data
);

	cfg_t cfg_q;
	logic f_push;
	rec_t f_rec;
	logic q_valid;
	rec_t q_rec;
	logic q_pop;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag      <= FLAG_RST;
			cfg_q.escape    <= ESCAPE_RST;
			cfg_q.address   <= ADDRESS_RST;
			cfg_q.ctrl_even <= CTRL_EV_RST;
			cfg_q.ctrl_odd  <= CTRL_OD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FLAG:    cfg_q.flag      <= cfg_data;
				REG_ESCAPE:  cfg_q.escape    <= cfg_data;
				REG_ADDRESS: cfg_q.address   <= cfg_data;
				REG_CTRL_EV: cfg_q.ctrl_even <= cfg_data;
				REG_CTRL_OD: cfg_q.ctrl_odd  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front end
	sfb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.push         (push),
		.q_full       (full),
		.payload_byte (payload_byte),
		.frame_last   (frame_last),
		.q_push       (f_push),
		.q_rec        (f_rec)
	);

	// decoupling queue
	sfb_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wr_rec (f_rec),
		.full   (full),
		.pop    (q_pop),
		.rd_rec (q_rec),
		.valid  (q_valid)
	);

	// back end
	sfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_rec      (q_rec),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.line_byte  (line_byte),
		.frame_done (frame_done),
		.run_last   (run_last)
	);

	`SFB_ASSERT_IMP(a_close_ends_run, clk, arst_n, !empty && frame_done, run_last, "close not last")

endmodule
